// ===== rtl/csi_pkg.sv =====
// shared constants for the circle segment interval block
package csi_pkg;
	localparam int RADIUS_W = 16;
	localparam int ROOT_W = 32;
	localparam logic [ROOT_W-1:0] ROOT_MAX = 32'h7FFF_FFFF;
	localparam logic [ROOT_W-1:0] ROOT_MIN = 32'h8000_0000;
endpackage

// ===== rtl/csi_in_if.sv =====
// input channel: one point and one segment per word
interface csi_in_if #(parameter int COORD_BITS = 16);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;
	modport source (output valid, point_x, point_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, input ready);
	modport sink (input valid, point_x, point_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, output ready);
endinterface

// ===== rtl/csi_out_if.sv =====
// output channel: flags and both roots per word
interface csi_out_if;
	logic valid;
	logic ready;
	logic valid_res;
	logic degenerate;
	logic signed [csi_pkg::ROOT_W-1:0] lower_root;
	logic signed [csi_pkg::ROOT_W-1:0] upper_root;
	modport source (output valid, valid_res, degenerate, lower_root, upper_root,
		input ready);
	modport sink (input valid, valid_res, degenerate, lower_root, upper_root,
		output ready);
endinterface

// ===== rtl/csi_cfg_if.sv =====
// configuration write channel carrying the radius
interface csi_cfg_if;
	logic valid;
	logic ready;
	logic [csi_pkg::RADIUS_W-1:0] radius;
	modport source (output valid, radius, input ready);
	modport sink (input valid, radius, output ready);
endinterface

// ===== rtl/csi_sqrt_cell.sv =====
// one cell of the square root chain, one root bit per cell
module csi_sqrt_cell #(
	parameter int SQ = 4,
	parameter int RW = 8,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                ce,
	input  logic [RW-1:0]       rad_i,
	input  logic [SQ+2:0]       rem_i,
	input  logic [SQ-1:0]       root_i,
	input  logic [SW-1:0]       side_i,
	output logic [RW-1:0]       rad_o,
	output logic [SQ+2:0]       rem_o,
	output logic [SQ-1:0]       root_o,
	output logic [SW-1:0]       side_o
);
	localparam int REM_W = SQ + 3;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic ge;

	always_comb begin
		rem_sh = {rem_i[REM_W-3:0], rad_i[RW-1:RW-2]};
		trial = REM_W'({root_i, 2'b01});
		ge = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rad_o <= {rad_i[RW-3:0], 2'b00};
			rem_o <= ge ? rem_sh - trial : rem_sh;
			root_o <= {root_i[SQ-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule

// ===== rtl/csi_div_cell.sv =====
// one cell of the restoring divider chain, one quotient bit per cell
module csi_div_cell #(
	parameter int NM = 8,
	parameter int AW = 4,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          ce,
	input  logic [NM-1:0] num_i,
	input  logic [AW-1:0] rem_i,
	input  logic [NM-1:0] q_i,
	input  logic [AW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic [NM-1:0] num_o,
	output logic [AW-1:0] rem_o,
	output logic [NM-1:0] q_o,
	output logic [AW-1:0] den_o,
	output logic [SW-1:0] side_o
);
	logic [AW:0] rem_sh;
	logic [AW:0] diff;
	logic ge;

	always_comb begin
		rem_sh = {rem_i, num_i[NM-1]};
		diff = rem_sh - {1'b0, den_i};
		ge = rem_sh >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			num_o <= {num_i[NM-2:0], 1'b0};
			rem_o <= ge ? diff[AW-1:0] : rem_sh[AW-1:0];
			q_o <= {q_i[NM-2:0], ge};
			den_o <= den_i;
			side_o <= side_i;
		end
	end
endmodule

// ===== rtl/circle_segment_interval.sv =====
// top level: circle and segment line intersection roots in fixed point
//
// channel  dir  payload
// req      in   point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
// rsp      out  valid_res, degenerate, lower_root, upper_root
// cfg      in   radius
//
// one word per cycle in and out while the output word is taken; the pipeline runs through
// the square root cell chain (SQ cells) and the divider cell chains (NM cells)
// the whole pipeline holds when the output word is not taken
// arst_n clears the radius and the pipeline valid bits
module circle_segment_interval #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	csi_in_if.sink req,
	csi_out_if.source rsp,
	csi_cfg_if.sink cfg
);
	localparam int RDW = csi_pkg::RADIUS_W;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int AW = 2 * COORD_BITS + 2;
	localparam int HW = 2 * COORD_BITS + 3;
	localparam int HM = 2 * COORD_BITS + 2;
	localparam int CM = (HM > 2 * RDW) ? HM : 2 * RDW;
	localparam int CW = CM + 1;
	localparam int PH = (CM + 1) / 2;
	localparam int MW2 = 2 * PH;
	localparam int W2 = 2 * MW2;
	localparam int DSW = W2 + 1;
	localparam int SQ = (DSW + 2 * FRAC_BITS + 1) / 2;
	localparam int RW = 2 * SQ;
	localparam int NM = ((HM + FRAC_BITS > SQ + 1) ? HM + FRAC_BITS : SQ + 1) + 1;
	localparam int NS = NM + 1;
	localparam int SQ_SW = 2 + HW + AW;
	localparam int L = 8 + SQ + NM;

	logic [RDW-1:0] radius_q;
	logic [L-1:0] vld_q;
	logic ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg.valid) begin
			radius_q <= cfg.radius;
		end
	end
	assign cfg.ready = 1'b1;

	assign ce = !vld_q[L-1] || rsp.ready;
	assign req.ready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[L-2:0], req.valid};
		end
	end

	// differences
	logic signed [DW-1:0] ex_s1, ey_s1, dx_s1, dy_s1;
	logic [RDW-1:0] rr_s1;
	always_ff @(posedge clk) begin
		if (ce) begin
			ex_s1 <= DW'(req.seg_start_x) - DW'(req.point_x);
			ey_s1 <= DW'(req.seg_start_y) - DW'(req.point_y);
			dx_s1 <= DW'(req.seg_end_x) - DW'(req.seg_start_x);
			dy_s1 <= DW'(req.seg_end_y) - DW'(req.seg_start_y);
			rr_s1 <= radius_q;
		end
	end

	// products
	logic signed [PW-1:0] dx2_s2, dy2_s2, exdx_s2, eydy_s2, ex2_s2, ey2_s2;
	logic [2*RDW-1:0] rr_s2;
	always_ff @(posedge clk) begin
		if (ce) begin
			dx2_s2 <= dx_s1 * dx_s1;
			dy2_s2 <= dy_s1 * dy_s1;
			exdx_s2 <= ex_s1 * dx_s1;
			eydy_s2 <= ey_s1 * dy_s1;
			ex2_s2 <= ex_s1 * ex_s1;
			ey2_s2 <= ey_s1 * ey_s1;
			rr_s2 <= (2*RDW)'(rr_s1) * (2*RDW)'(rr_s1);
		end
	end

	// quadratic coefficients
	logic [AW-1:0] a_sum;
	logic [AW-1:0] a_s3;
	logic signed [HW-1:0] h_s3;
	logic signed [CW-1:0] c_s3;
	logic degen_s3;
	assign a_sum = AW'($unsigned(dx2_s2)) + AW'($unsigned(dy2_s2));
	always_ff @(posedge clk) begin
		if (ce) begin
			a_s3 <= a_sum;
			h_s3 <= HW'(exdx_s2) + HW'(eydy_s2);
			c_s3 <= CW'(ex2_s2) + CW'(ey2_s2) - CW'(rr_s2);
			degen_s3 <= a_sum == '0;
		end
	end

	// partial products of h*h and a*|c|
	logic [HW-1:0] hneg;
	logic [CW-1:0] cneg_v;
	logic [MW2-1:0] hmx, cmx, amx;
	assign hneg = HW'(0) - h_s3;
	assign cneg_v = CW'(0) - c_s3;
	assign hmx = MW2'(h_s3[HW-1] ? hneg[HM-1:0] : h_s3[HM-1:0]);
	assign cmx = MW2'(c_s3[CW-1] ? cneg_v[CM-1:0] : c_s3[CM-1:0]);
	assign amx = MW2'(a_s3);

	logic [MW2-1:0] hh_ll_s4, hh_lh_s4, hh_hh_s4;
	logic [MW2-1:0] ac_ll_s4, ac_lh_s4, ac_hl_s4, ac_hh_s4;
	logic [AW-1:0] a_s4;
	logic signed [HW-1:0] h_s4;
	logic cneg_s4, degen_s4;
	always_ff @(posedge clk) begin
		if (ce) begin
			hh_ll_s4 <= MW2'(hmx[PH-1:0]) * MW2'(hmx[PH-1:0]);
			hh_lh_s4 <= MW2'(hmx[PH-1:0]) * MW2'(hmx[MW2-1:PH]);
			hh_hh_s4 <= MW2'(hmx[MW2-1:PH]) * MW2'(hmx[MW2-1:PH]);
			ac_ll_s4 <= MW2'(amx[PH-1:0]) * MW2'(cmx[PH-1:0]);
			ac_lh_s4 <= MW2'(amx[PH-1:0]) * MW2'(cmx[MW2-1:PH]);
			ac_hl_s4 <= MW2'(amx[MW2-1:PH]) * MW2'(cmx[PH-1:0]);
			ac_hh_s4 <= MW2'(amx[MW2-1:PH]) * MW2'(cmx[MW2-1:PH]);
			a_s4 <= a_s3;
			h_s4 <= h_s3;
			cneg_s4 <= c_s3[CW-1];
			degen_s4 <= degen_s3;
		end
	end

	// full products
	logic [W2-1:0] h2_s5, ac_s5;
	logic [AW-1:0] a_s5;
	logic signed [HW-1:0] h_s5;
	logic cneg_s5, degen_s5;
	always_ff @(posedge clk) begin
		if (ce) begin
			h2_s5 <= W2'(hh_ll_s4) + (W2'(hh_lh_s4) << (PH + 1)) + (W2'(hh_hh_s4) << MW2);
			ac_s5 <= W2'(ac_ll_s4) + ((W2'(ac_lh_s4) + W2'(ac_hl_s4)) << PH)
				+ (W2'(ac_hh_s4) << MW2);
			a_s5 <= a_s4;
			h_s5 <= h_s4;
			cneg_s5 <= cneg_s4;
			degen_s5 <= degen_s4;
		end
	end

	// discriminant and radicand
	logic [DSW-1:0] disc;
	logic negd;
	logic [RW-1:0] rad_s6;
	logic [SQ_SW-1:0] side_s6;
	always_comb begin
		negd = !cneg_s5 && (h2_s5 < ac_s5);
		disc = cneg_s5 ? DSW'(h2_s5) + DSW'(ac_s5) : DSW'(h2_s5) - DSW'(ac_s5);
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			rad_s6 <= RW'({disc, {(2 * FRAC_BITS){1'b0}}});
			side_s6 <= {!degen_s5 && !negd, degen_s5, h_s5, a_s5};
		end
	end

	// square root chain
	logic [RW-1:0] sq_rad [0:SQ];
	logic [SQ+2:0] sq_rem [0:SQ];
	logic [SQ-1:0] sq_root [0:SQ];
	logic [SQ_SW-1:0] sq_side [0:SQ];
	assign sq_rad[0] = rad_s6;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s6;

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		csi_sqrt_cell #(.SQ(SQ), .RW(RW), .SW(SQ_SW)) u_cell (
			.clk(clk), .ce(ce),
			.rad_i(sq_rad[i]), .rem_i(sq_rem[i]), .root_i(sq_root[i]), .side_i(sq_side[i]),
			.rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1]),
			.side_o(sq_side[i+1])
		);
	end

	// numerators of both roots
	logic signed [HW-1:0] h_sq;
	logic [AW-1:0] a_sq;
	logic signed [NS-1:0] base, nu, nl, nu_neg, nl_neg, s_ext, cs_ext;
	assign h_sq = sq_side[SQ][AW+HW-1:AW];
	assign a_sq = sq_side[SQ][AW-1:0];
	always_comb begin
		base = NS'(0) - (NS'(h_sq) <<< FRAC_BITS);
		s_ext = NS'(sq_root[SQ]);
		cs_ext = s_ext + NS'(sq_rem[SQ] != '0);
		nu = base + s_ext;
		nl = base - cs_ext;
		nu_neg = NS'(0) - nu;
		nl_neg = NS'(0) - nl;
	end

	logic [NM-1:0] numl_s7, numu_s7;
	logic [AW-1:0] a_s7;
	logic [2:0] sidel_s7;
	logic sideu_s7;
	always_ff @(posedge clk) begin
		if (ce) begin
			numl_s7 <= nl[NS-1] ? nl_neg[NM-1:0] : nl[NM-1:0];
			numu_s7 <= nu[NS-1] ? nu_neg[NM-1:0] : nu[NM-1:0];
			a_s7 <= a_sq;
			sidel_s7 <= {sq_side[SQ][SQ_SW-1], sq_side[SQ][SQ_SW-2], nl[NS-1]};
			sideu_s7 <= nu[NS-1];
		end
	end

	// divider chains
	logic [NM-1:0] dl_num [0:NM];
	logic [AW-1:0] dl_rem [0:NM];
	logic [NM-1:0] dl_q [0:NM];
	logic [AW-1:0] dl_den [0:NM];
	logic [2:0] dl_side [0:NM];
	logic [NM-1:0] du_num [0:NM];
	logic [AW-1:0] du_rem [0:NM];
	logic [NM-1:0] du_q [0:NM];
	logic [AW-1:0] du_den [0:NM];
	logic [0:0] du_side [0:NM];
	assign dl_num[0] = numl_s7;
	assign dl_rem[0] = '0;
	assign dl_q[0] = '0;
	assign dl_den[0] = a_s7;
	assign dl_side[0] = sidel_s7;
	assign du_num[0] = numu_s7;
	assign du_rem[0] = '0;
	assign du_q[0] = '0;
	assign du_den[0] = a_s7;
	assign du_side[0] = sideu_s7;

	for (genvar i = 0; i < NM; i++) begin : g_div
		csi_div_cell #(.NM(NM), .AW(AW), .SW(3)) u_lower (
			.clk(clk), .ce(ce),
			.num_i(dl_num[i]), .rem_i(dl_rem[i]), .q_i(dl_q[i]), .den_i(dl_den[i]),
			.side_i(dl_side[i]),
			.num_o(dl_num[i+1]), .rem_o(dl_rem[i+1]), .q_o(dl_q[i+1]), .den_o(dl_den[i+1]),
			.side_o(dl_side[i+1])
		);
		csi_div_cell #(.NM(NM), .AW(AW), .SW(1)) u_upper (
			.clk(clk), .ce(ce),
			.num_i(du_num[i]), .rem_i(du_rem[i]), .q_i(du_q[i]), .den_i(du_den[i]),
			.side_i(du_side[i]),
			.num_o(du_num[i+1]), .rem_o(du_rem[i+1]), .q_o(du_q[i+1]), .den_o(du_den[i+1]),
			.side_o(du_side[i+1])
		);
	end

	// floor toward minus infinity and saturate
	function automatic logic [csi_pkg::ROOT_W-1:0] sat_root(
		input logic [NM-1:0] q,
		input logic inexact,
		input logic neg
	);
		logic [NM:0] mag;
		logic [NM:0] mneg;
		logic [csi_pkg::ROOT_W-1:0] r;
		mag = {1'b0, q} + (NM+1)'(neg && inexact);
		mneg = (NM+1)'(0) - mag;
		if (neg) begin
			r = (mag >= (NM+1)'(csi_pkg::ROOT_MIN)) ? csi_pkg::ROOT_MIN
				: mneg[csi_pkg::ROOT_W-1:0];
		end else begin
			r = (mag > (NM+1)'(csi_pkg::ROOT_MAX)) ? csi_pkg::ROOT_MAX
				: mag[csi_pkg::ROOT_W-1:0];
		end
		return r;
	endfunction

	logic ok_d;
	logic valid_res_s9, degenerate_s9;
	logic [csi_pkg::ROOT_W-1:0] lower_s9, upper_s9;
	assign ok_d = dl_side[NM][2];
	always_ff @(posedge clk) begin
		if (ce) begin
			valid_res_s9 <= ok_d;
			degenerate_s9 <= dl_side[NM][1];
			lower_s9 <= ok_d ? sat_root(dl_q[NM], dl_rem[NM] != '0, dl_side[NM][0]) : '0;
			upper_s9 <= ok_d ? sat_root(du_q[NM], du_rem[NM] != '0, du_side[NM][0]) : '0;
		end
	end

	assign rsp.valid = vld_q[L-1];
	assign rsp.valid_res = valid_res_s9;
	assign rsp.degenerate = degenerate_s9;
	assign rsp.lower_root = lower_s9;
	assign rsp.upper_root = upper_s9;
endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for circle_segment_interval with its own root predictor
`timescale 1ns / 1ps
module testbench;
	localparam int FRAC = 16;
	localparam int DRAIN = 160;
	localparam int LIMIT = 600000;

	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} seg_query_t;

	typedef struct {
		logic valid_res;
		logic degenerate;
		logic [csi_pkg::ROOT_W-1:0] lower;
		logic [csi_pkg::ROOT_W-1:0] upper;
	} root_word_t;

	typedef struct {
		seg_query_t q;
		bit typed;
		root_word_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	csi_in_if #(.COORD_BITS(16)) req_if();
	csi_out_if rsp_if();
	csi_cfg_if cfg_if();

	circle_segment_interval dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	root_word_t pending_roots[$];
	logic [csi_pkg::RADIUS_W-1:0] cur_radius;
	int errors;
	int cycles;
	int burst_left;
	int hold_cnt;
	int ready_mode;
	dir_row_t dir_rows[];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [127:0] isqrt128(input logic [127:0] x);
		logic [127:0] r;
		logic [127:0] cand;
		r = 0;
		for (int i = 55; i >= 0; i--) begin
			cand = r | (128'd1 << i);
			if (cand * cand <= x)
				r = cand;
		end
		return r;
	endfunction

	function automatic logic [csi_pkg::ROOT_W-1:0] floor_div_sat(
		input logic signed [127:0] n,
		input longint d);
		logic signed [127:0] dd;
		logic signed [127:0] q;
		dd = d;
		q = n / dd;
		if ((n % dd) != 0 && n < 0)
			q = q - 1;
		if (q > 128'sd2147483647)
			return csi_pkg::ROOT_MAX;
		if (q < -128'sd2147483648)
			return csi_pkg::ROOT_MIN;
		return q[csi_pkg::ROOT_W-1:0];
	endfunction

	function automatic root_word_t predict_roots(input seg_query_t q,
		input logic [csi_pkg::RADIUS_W-1:0] rad);
		longint ox, oy, dx, dy, a, h, c;
		logic [127:0] habs, cabs, h2, ac, disc, sh, s, cs;
		logic signed [127:0] hs, base, nu, nl;
		root_word_t r;
		r = '{1'b0, 1'b0, '0, '0};
		ox = longint'(q.sx) - longint'(q.px);
		oy = longint'(q.sy) - longint'(q.py);
		dx = longint'(q.ex) - longint'(q.sx);
		dy = longint'(q.ey) - longint'(q.sy);
		a = dx * dx + dy * dy;
		if (a == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		h = ox * dx + oy * dy;
		c = ox * ox + oy * oy - longint'(rad) * longint'(rad);
		habs = 128'(h < 0 ? -h : h);
		cabs = 128'(c < 0 ? -c : c);
		h2 = habs * habs;
		ac = 128'(a) * cabs;
		if (c < 0) begin
			disc = h2 + ac;
		end else begin
			if (h2 < ac)
				return r;
			disc = h2 - ac;
		end
		sh = disc << (2 * FRAC);
		s = isqrt128(sh);
		cs = (s * s == sh) ? s : s + 1;
		hs = habs;
		base = (h > 0) ? -(hs <<< FRAC) : (hs <<< FRAC);
		nu = base + $signed(s);
		nl = base - $signed(cs);
		r.valid_res = 1'b1;
		r.lower = floor_div_sat(nl, a);
		r.upper = floor_div_sat(nu, a);
		return r;
	endfunction

	task automatic send_query(input seg_query_t q, input bit typed, input root_word_t want);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.point_x <= q.px;
		req_if.point_y <= q.py;
		req_if.seg_start_x <= q.sx;
		req_if.seg_start_y <= q.sy;
		req_if.seg_end_x <= q.ex;
		req_if.seg_end_y <= q.ey;
		do @(posedge clk); while (!req_if.ready);
		pending_roots.push_back(typed ? want : predict_roots(q, cur_radius));
	endtask

	task automatic write_radius(input logic [csi_pkg::RADIUS_W-1:0] v);
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.radius <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		cur_radius = v;
	endtask

	task automatic random_phase(input int n);
		seg_query_t q;
		int span, mode;
		logic [15:0] cx, cy;
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(0, 3);
			span = (int'(cur_radius) > 2000 ? 2000 : int'(cur_radius)) + 8;
			if (mode == 0) begin
				q.px = 16'($urandom); q.py = 16'($urandom);
				q.sx = 16'($urandom); q.sy = 16'($urandom);
				q.ex = 16'($urandom); q.ey = 16'($urandom);
			end else begin
				cx = 16'($urandom);
				cy = 16'($urandom);
				q.px = cx;
				q.py = cy;
				q.sx = cx + 16'(int'($urandom_range(0, 4 * span)) - 2 * span);
				q.sy = cy + 16'(int'($urandom_range(0, 4 * span)) - 2 * span);
				q.ex = cx + 16'(int'($urandom_range(0, 4 * span)) - 2 * span);
				q.ey = cy + 16'(int'($urandom_range(0, 4 * span)) - 2 * span);
			end
			if ($urandom_range(0, 19) == 0) begin
				q.ex = q.sx;
				q.ey = q.sy;
			end
			send_query(q, 1'b0, '{1'b0, 1'b0, '0, '0});
		end
	endtask

	initial begin
		dir_rows = '{
			'{'{16'sd5, 16'sd5, 16'sd3, 16'sd3, 16'sd3, 16'sd3}, 1'b1,
				'{1'b0, 1'b1, 32'h0, 32'h0}},
			'{'{16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd10, 16'sd0}, 1'b1,
				'{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{16'sd0, 16'sd0, -16'sd10, 16'sd0, 16'sd10, 16'sd0}, 1'b1,
				'{1'b1, 1'b0, 32'h0, 32'h0001_0000}},
			'{'{16'sd0, 16'sd10, -16'sd10, 16'sd0, 16'sd10, 16'sd0}, 1'b1,
				'{1'b1, 1'b0, 32'h0000_8000, 32'h0000_8000}},
			'{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b1,
				'{1'b1, 1'b0, csi_pkg::ROOT_MIN, 32'h800A_0000}},
			'{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b1,
				'{1'b1, 1'b0, 32'h7FF5_0000, csi_pkg::ROOT_MAX}},
			'{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
				1'b1, '{1'b0, 1'b1, 32'h0, 32'h0}},
			'{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{16'sd0, 16'sd0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{-16'sd1, -16'sd1, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd6, 16'sd8},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}},
			'{'{16'sd7, -16'sd3, 16'sd7, -16'sd13, 16'sd7, 16'sd20},
				1'b0, '{1'b0, 1'b0, 32'h0, 32'h0}}
		};
		errors = 0;
		burst_left = 0;
		cur_radius = '0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.point_x = '0;
		req_if.point_y = '0;
		req_if.seg_start_x = '0;
		req_if.seg_start_y = '0;
		req_if.seg_end_x = '0;
		req_if.seg_end_y = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.radius = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		random_phase(200);
		write_radius(16'd10);
		foreach (dir_rows[i])
			send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want);
		random_phase(200);
		write_radius(16'hFFFF);
		random_phase(250);
		write_radius(16'd1);
		random_phase(250);
		write_radius(16'd0);
		random_phase(200);
		for (int p = 0; p < 3; p++) begin
			write_radius(p == 0 ? 16'($urandom_range(2, 300)) : 16'($urandom));
			random_phase(250);
		end

		req_if.valid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_cnt <= 0) begin
			hold_cnt <= $urandom_range(1, 40);
			ready_mode <= $urandom_range(0, 3);
		end else begin
			hold_cnt <= hold_cnt - 1;
		end
		rsp_if.ready <= (ready_mode == 0) ? 1'b1 : (ready_mode == 1) ? 1'b0 :
			(ready_mode == 2) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) != 0);
	end

	initial begin
		hold_cnt = 0;
		ready_mode = 0;
	end

	always @(posedge clk) begin
		root_word_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected word valid_res=%b degenerate=%b lower=%h upper=%h",
					$time, rsp_if.valid_res, rsp_if.degenerate, rsp_if.lower_root,
					rsp_if.upper_root);
				errors++;
			end else begin
				want = pending_roots.pop_front();
				if (rsp_if.valid_res !== want.valid_res) begin
					$display("%0t: valid_res expected %b actual %b", $time, want.valid_res,
						rsp_if.valid_res);
					errors++;
				end
				if (rsp_if.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
						rsp_if.degenerate);
					errors++;
				end
				if (rsp_if.lower_root !== want.lower) begin
					$display("%0t: lower_root expected %h actual %h", $time, want.lower,
						rsp_if.lower_root);
					errors++;
				end
				if (rsp_if.upper_root !== want.upper) begin
					$display("%0t: upper_root expected %h actual %h", $time, want.upper,
						rsp_if.upper_root);
					errors++;
				end
			end
		end
	end

	initial cycles = 0;
endmodule

// ===== filelist.f =====
rtl/csi_pkg.sv
rtl/csi_in_if.sv
rtl/csi_out_if.sv
rtl/csi_cfg_if.sv
rtl/csi_sqrt_cell.sv
rtl/csi_div_cell.sv
rtl/circle_segment_interval.sv
tb/sv/testbench.sv
